FILE: sv/atsl_pkg.sv
// ============================================================================
// atsl_pkg: shared types and constants of the temperature sensor linearizer
// Holds the calibration ROM, the field widths, the controller state type
// and the command and status bundles between controller and datapath.
// ============================================================================
package atsl_pkg;

  localparam int CODE_W        = 12;
  localparam int MV_W          = 12;
  localparam int DEG_W         = 8;
  localparam int PROD_W        = CODE_W + MV_W;
  localparam int NUM_W         = MV_W + DEG_W;
  localparam int TABLE_ENTRIES = 21;
  localparam int SEG_W         = $clog2(TABLE_ENTRIES);
  localparam int DIV_CNT_W     = $clog2(DEG_W);

  localparam logic [MV_W-1:0]  VREF_MV         = 12'd3300;
  localparam logic [MV_W:0]    CODE_FULL_SCALE = 13'd4095;
  localparam logic [DEG_W-1:0] TEMP_MAX        = 8'd150;

  localparam logic [MV_W-1:0] ROM_MV [TABLE_ENTRIES] = '{
    12'd3290, 12'd3160, 12'd3030, 12'd2899, 12'd2767, 12'd2634, 12'd2501,
    12'd2366, 12'd2231, 12'd2095, 12'd1957, 12'd1819, 12'd1681, 12'd1541,
    12'd1400, 12'd1259, 12'd1117, 12'd973,  12'd829,  12'd684,  12'd539
  };

  localparam logic [DEG_W-1:0] ROM_DEG [TABLE_ENTRIES] = '{
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd10,
    8'd20,  8'd30,  8'd40,  8'd50,  8'd60,  8'd70,  8'd80,
    8'd90,  8'd100, 8'd110, 8'd120, 8'd130, 8'd140, 8'd150
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MV,
    ST_SEARCH,
    ST_PROD,
    ST_DIV,
    ST_ADD,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic accept;
    logic calc_mv;
    logic next_k;
    logic set_direct;
    logic load_seg;
    logic set_flat;
    logic load_prod;
    logic div_step;
    logic set_interp;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic direct;
    logic hit;
    logic flat;
    logic div_last;
  } dp_status_t;

endpackage

FILE: sv/adc_temp_sensor_linearizer_unit.sv
// ============================================================================
// adc_temp_sensor_linearizer_unit: converter code to degrees Celsius
// Scales a 12-bit sensor code to millivolts and interpolates a fixed
// 21-point calibration table into whole degrees, clamped to its ends.
// ============================================================================
// Usage:
// The input channel (in_valid, in_stall, in_adc_code) takes one beat when
// in_valid is high and in_stall is low. The result channel (out_valid,
// out_stall, out_temperature_c) gives exactly one beat per input beat.
// One beat is worked on at a time: in_stall stays high from acceptance
// until the result is moved into the output register.
// The product is taken at acceptance; then millivolts are formed and the
// table segments are searched in order, and a clamped voltage goes
// straight to the load. Otherwise the hit segment is loaded and, unless its
// span is zero, the product is loaded, the divider yields one quotient bit
// per cycle for eight bits, and one add and one load follow. The next beat
// can be taken in the cycle after the load.
// The output register parts the channels: while a result waits under
// out_stall the next beat is still accepted and worked on, and it only
// waits at the final load for the register to free up.
// Reset clears the sequencer and the output valid; the datapath registers
// are not reset and need no clearing pass.
// ============================================================================
module adc_temp_sensor_linearizer_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [atsl_pkg::CODE_W-1:0]       in_adc_code,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [atsl_pkg::DEG_W-1:0]        out_temperature_c
);

  atsl_pkg::ctrl_cmd_t  cmd;
  atsl_pkg::dp_status_t status;

  atsl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  atsl_datapath u_datapath (
    .clk               (clk),
    .in_adc_code       (in_adc_code),
    .cmd               (cmd),
    .status            (status),
    .out_temperature_c (out_temperature_c)
  );

`ifndef SYNTHESIS
  // An accepted beat keeps the input stalled on the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after an accepted beat");

  // A delivered temperature never exceeds the hot end of the table.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_temperature_c <= atsl_pkg::TEMP_MAX))
    else $error("temperature beyond table range");

  // The divider never runs on a zero span.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> !status.flat)
    else $error("divider stepped with a zero span");

  // A result is only loaded when the output register is free.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid || !out_stall))
    else $error("output register overwritten while stalled");
`endif

endmodule

FILE: sv/atsl_datapath.sv
// ============================================================================
// atsl_datapath: arithmetic of the temperature sensor linearizer
// Scales the code to millivolts, walks the ROM one segment per cycle,
// and interpolates with a restoring divider that yields one bit per cycle.
// ============================================================================
module atsl_datapath (
  input  logic                          clk,
  input  logic [atsl_pkg::CODE_W-1:0]   in_adc_code,
  input  atsl_pkg::ctrl_cmd_t           cmd,
  output atsl_pkg::dp_status_t          status,
  output logic [atsl_pkg::DEG_W-1:0]    out_temperature_c
);

  localparam int MV_W  = atsl_pkg::MV_W;
  localparam int DEG_W = atsl_pkg::DEG_W;
  localparam int NUM_W = atsl_pkg::NUM_W;
  localparam int SEG_W = atsl_pkg::SEG_W;
  localparam int LAST  = atsl_pkg::TABLE_ENTRIES - 1;

  logic [atsl_pkg::PROD_W-1:0]    prod_r;
  logic [MV_W-1:0]                mv_r;
  logic [SEG_W-1:0]               k_r;
  logic [DEG_W-1:0]               t0_r;
  logic [MV_W-1:0]                diff_r;
  logic [MV_W-1:0]                span_r;
  logic [DEG_W-1:0]               step_r;
  logic [MV_W-1:0]                rem_r;
  logic [DEG_W-1:0]               quo_r;
  logic [atsl_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [DEG_W-1:0]               res_r;
  logic [DEG_W-1:0]               out_temp_r;

  logic [MV_W-1:0]  q0;
  logic [MV_W:0]    r0;
  logic [MV_W-1:0]  mv_calc;
  logic [SEG_W-1:0] k_nx;
  logic             clamp_hi;
  logic             clamp_lo;
  logic             last_k;
  logic [DEG_W-1:0] direct_deg;
  logic [NUM_W-1:0] num;
  logic [MV_W:0]    div_ext;
  logic [MV_W:0]    div_sub;
  logic             div_ge;

  // Division by 4095: the high half is the first quotient guess, and the
  // remainder it leaves stays below twice the divisor.
  assign q0      = prod_r[atsl_pkg::PROD_W-1:MV_W];
  assign r0      = {1'b0, prod_r[MV_W-1:0]} + {1'b0, q0};
  assign mv_calc = (r0 >= atsl_pkg::CODE_FULL_SCALE) ? q0 + MV_W'(1) : q0;

  assign k_nx       = k_r + SEG_W'(1);
  assign clamp_hi   = mv_r >= atsl_pkg::ROM_MV[0];
  assign clamp_lo   = mv_r <= atsl_pkg::ROM_MV[LAST];
  assign last_k     = k_r == SEG_W'(LAST - 1);
  assign direct_deg = clamp_hi ? atsl_pkg::ROM_DEG[0] : atsl_pkg::ROM_DEG[LAST];

  assign status.hit      = (mv_r <= atsl_pkg::ROM_MV[k_r]) && (mv_r >= atsl_pkg::ROM_MV[k_nx]);
  assign status.direct   = clamp_hi || clamp_lo || (!status.hit && last_k);
  assign status.flat     = span_r == '0;
  assign status.div_last = cnt_r == atsl_pkg::DIV_CNT_W'(DEG_W - 1);

  assign num     = NUM_W'(diff_r) * NUM_W'(step_r);
  assign div_ext = {rem_r, quo_r[DEG_W-1]};
  assign div_ge  = div_ext >= {1'b0, span_r};
  assign div_sub = div_ext - {1'b0, span_r};

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      prod_r <= atsl_pkg::PROD_W'(in_adc_code) * atsl_pkg::PROD_W'(atsl_pkg::VREF_MV);
      k_r    <= '0;
    end
    if (cmd.calc_mv) begin
      mv_r <= mv_calc;
    end
    if (cmd.next_k) begin
      k_r <= k_nx;
    end
    if (cmd.set_direct) begin
      res_r <= direct_deg;
    end
    if (cmd.load_seg) begin
      t0_r   <= atsl_pkg::ROM_DEG[k_r];
      diff_r <= atsl_pkg::ROM_MV[k_r] - mv_r;
      span_r <= atsl_pkg::ROM_MV[k_r] - atsl_pkg::ROM_MV[k_nx];
      step_r <= (atsl_pkg::ROM_DEG[k_nx] >= atsl_pkg::ROM_DEG[k_r]) ?
                atsl_pkg::ROM_DEG[k_nx] - atsl_pkg::ROM_DEG[k_r] : '0;
    end
    if (cmd.set_flat) begin
      res_r <= t0_r;
    end
    if (cmd.load_prod) begin
      rem_r <= num[NUM_W-1:DEG_W];
      quo_r <= num[DEG_W-1:0];
      cnt_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= div_ge ? div_sub[MV_W-1:0] : div_ext[MV_W-1:0];
      quo_r <= {quo_r[DEG_W-2:0], div_ge};
      cnt_r <= cnt_r + atsl_pkg::DIV_CNT_W'(1);
    end
    if (cmd.set_interp) begin
      res_r <= t0_r + quo_r;
    end
    if (cmd.load_out) begin
      out_temp_r <= res_r;
    end
  end

  assign out_temperature_c = out_temp_r;

endmodule

FILE: sv/atsl_ctrl.sv
// ============================================================================
// atsl_ctrl: sequencer of the temperature sensor linearizer
// Steps one beat through scaling, segment search and division, and owns
// the handshakes of both channels.
// ============================================================================
module atsl_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  atsl_pkg::dp_status_t status,
  output atsl_pkg::ctrl_cmd_t  cmd
);

  atsl_pkg::state_t state_r;
  atsl_pkg::state_t state_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      atsl_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = atsl_pkg::ST_MV;
        end
      end
      atsl_pkg::ST_MV: begin
        state_nxt = atsl_pkg::ST_SEARCH;
      end
      atsl_pkg::ST_SEARCH: begin
        priority if (status.direct) begin
          state_nxt = atsl_pkg::ST_FIN;
        end else if (status.hit) begin
          state_nxt = atsl_pkg::ST_PROD;
        end else begin
          state_nxt = atsl_pkg::ST_SEARCH;
        end
      end
      atsl_pkg::ST_PROD: begin
        state_nxt = status.flat ? atsl_pkg::ST_FIN : atsl_pkg::ST_DIV;
      end
      atsl_pkg::ST_DIV: begin
        if (status.div_last) begin
          state_nxt = atsl_pkg::ST_ADD;
        end
      end
      atsl_pkg::ST_ADD: begin
        state_nxt = atsl_pkg::ST_FIN;
      end
      atsl_pkg::ST_FIN: begin
        if (out_free) begin
          state_nxt = atsl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = atsl_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      atsl_pkg::ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      atsl_pkg::ST_MV: begin
        cmd.calc_mv = 1'b1;
      end
      atsl_pkg::ST_SEARCH: begin
        cmd.set_direct = status.direct;
        cmd.load_seg   = !status.direct && status.hit;
        cmd.next_k     = !status.direct && !status.hit;
      end
      atsl_pkg::ST_PROD: begin
        cmd.set_flat  = status.flat;
        cmd.load_prod = !status.flat;
      end
      atsl_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      atsl_pkg::ST_ADD: begin
        cmd.set_interp = 1'b1;
      end
      atsl_pkg::ST_FIN: begin
        cmd.load_out = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  assign out_valid_nxt = cmd.load_out || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= atsl_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
